### hdl/pmpd_pkg.sv
package pmpd_pkg;

    localparam int unsigned MOUSE_FLAG_BIT = 5;
    localparam int unsigned NUM_BUTTONS    = 3;
    localparam int unsigned NUM_EVENT_SLOTS = NUM_BUTTONS + 1;
    localparam int unsigned DEF_QUEUE_DEPTH = 2;

    typedef enum logic [1:0] {
        EV_MOVE    = 2'd0,
        EV_PRESS   = 2'd1,
        EV_RELEASE = 2'd2
    } event_kind_t;

    // Packet descriptor handed from front to back.
    // events[0] is the move event, events[i] is button i.
    typedef struct packed {
        logic [7:0]                 dx;
        logic [8:0]                 dy;
        logic [NUM_EVENT_SLOTS-1:0] events;
        logic [NUM_BUTTONS-1:0]     released;
    } pkt_t;

    typedef struct packed {
        logic full;
        logic empty;
    } qstat_t;

endpackage

### hdl/pmpd_if.sv
interface pmpd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] status_byte;
    logic [7:0] data_byte;

    modport source (output valid, output status_byte, output data_byte, input ready);
    modport sink   (input valid, input status_byte, input data_byte, output ready);
endinterface

interface pmpd_event_if;
    logic              valid;
    logic              ready;
    logic [1:0]        event_kind;
    logic signed [7:0] delta_x;
    logic signed [8:0] delta_y;
    logic [1:0]        button_number;
    logic              last_event;

    modport source (output valid, output event_kind, output delta_x, output delta_y,
                    output button_number, output last_event, input ready);
    modport sink   (input valid, input event_kind, input delta_x, input delta_y,
                    input button_number, input last_event, output ready);
endinterface

### hdl/pmpd_front.sv
module pmpd_front (
    input  logic           clk,
    input  logic           rst_n,
    pmpd_byte_if.sink      byte_ch,
    input  pmpd_pkg::qstat_t q_stat,
    output logic           push,
    output pmpd_pkg::pkt_t push_pkt
);
    import pmpd_pkg::*;

    logic [1:0]             byte_position_reg, byte_position_next;
    logic [7:0]             flags_byte_reg, flags_byte_next;
    logic [7:0]             x_byte_reg, x_byte_next;
    logic [NUM_BUTTONS-1:0] button_state_reg, button_state_next;
    logic                   accept;
    logic                   mouse_byte;
    logic                   third;
    logic                   moved;
    logic [NUM_BUTTONS-1:0] changed;

    assign byte_ch.ready = !q_stat.full;
    assign accept        = byte_ch.valid && byte_ch.ready;
    assign mouse_byte    = byte_ch.status_byte[MOUSE_FLAG_BIT];
    assign third         = byte_position_reg[1];

    assign moved   = (x_byte_reg != 8'd0) || (byte_ch.data_byte != 8'd0);
    assign changed = flags_byte_reg[NUM_BUTTONS-1:0] ^ button_state_reg;

    always_comb
    begin
        push_pkt.dx       = x_byte_reg;
        push_pkt.dy       = 9'd0 - {byte_ch.data_byte[7], byte_ch.data_byte};
        push_pkt.events   = {changed, moved};
        push_pkt.released = button_state_reg;
    end

    // Drop quiet packets; only a packet with events enters the queue.
    assign push = accept && mouse_byte && third && (moved || (changed != '0));

    always_comb
    begin
        byte_position_next = byte_position_reg;
        flags_byte_next    = flags_byte_reg;
        x_byte_next        = x_byte_reg;
        button_state_next  = button_state_reg;
        if (accept && mouse_byte)
        begin
            if (third)
            begin
                byte_position_next = 2'd0;
                button_state_next  = flags_byte_reg[NUM_BUTTONS-1:0];
            end
            else if (byte_position_reg[0])
            begin
                x_byte_next        = byte_ch.data_byte;
                byte_position_next = 2'd2;
            end
            else
            begin
                flags_byte_next    = byte_ch.data_byte;
                byte_position_next = 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_position_reg <= 2'd0;
            flags_byte_reg    <= 8'd0;
            x_byte_reg        <= 8'd0;
            button_state_reg  <= '0;
        end
        else
        begin
            byte_position_reg <= byte_position_next;
            flags_byte_reg    <= flags_byte_next;
            x_byte_reg        <= x_byte_next;
            button_state_reg  <= button_state_next;
        end
    end

endmodule

### hdl/pmpd_queue.sv
module pmpd_queue #(
    parameter int unsigned DEPTH = pmpd_pkg::DEF_QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  pmpd_pkg::pkt_t   push_pkt,
    input  logic             pop,
    output pmpd_pkg::pkt_t   pop_pkt,
    output pmpd_pkg::qstat_t q_stat
);
    import pmpd_pkg::*;

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    pkt_t          entry_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    assign q_stat.full  = (count_reg == FULL_CNT);
    assign q_stat.empty = (count_reg == '0);
    assign pop_pkt      = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_pkt;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

### hdl/pmpd_back.sv
module pmpd_back (
    input  logic             clk,
    input  logic             rst_n,
    input  pmpd_pkg::qstat_t q_stat,
    input  pmpd_pkg::pkt_t   pop_pkt,
    output logic             pop,
    pmpd_event_if.source     event_ch
);
    import pmpd_pkg::*;

    pkt_t                       cur_reg, cur_next;
    logic                       cur_valid_reg, cur_valid_next;
    logic [NUM_EVENT_SLOTS-1:0] pend_after;
    logic                       emit;
    logic                       out_free;

    logic              out_valid_reg, out_valid_next;
    event_kind_t       kind_reg, kind_next;
    logic signed [7:0] dx_reg, dx_next;
    logic signed [8:0] dy_reg, dy_next;
    logic [1:0]        button_reg, button_next;
    logic              last_reg, last_next;

    assign out_free = !out_valid_reg || event_ch.ready;
    assign emit     = cur_valid_reg && out_free;
    // Clear the lowest pending event slot.
    assign pend_after = cur_reg.events & (cur_reg.events - 1'b1);
    assign pop = !q_stat.empty && (!cur_valid_reg || (emit && (pend_after == '0)));

    always_comb
    begin
        kind_next   = EV_MOVE;
        dx_next     = '0;
        dy_next     = '0;
        button_next = 2'd0;
        if (cur_reg.events[0])
        begin
            dx_next = cur_reg.dx;
            dy_next = cur_reg.dy;
        end
        else if (cur_reg.events[1])
        begin
            kind_next   = cur_reg.released[0] ? EV_RELEASE : EV_PRESS;
            button_next = 2'd1;
        end
        else if (cur_reg.events[2])
        begin
            kind_next   = cur_reg.released[1] ? EV_RELEASE : EV_PRESS;
            button_next = 2'd2;
        end
        else
        begin
            kind_next   = cur_reg.released[2] ? EV_RELEASE : EV_PRESS;
            button_next = 2'd3;
        end
        last_next = (pend_after == '0);
    end

    always_comb
    begin
        cur_next       = cur_reg;
        cur_valid_next = cur_valid_reg;
        if (emit)
        begin
            cur_next.events = pend_after;
            cur_valid_next  = (pend_after != '0);
        end
        if (pop)
        begin
            cur_next       = pop_pkt;
            cur_valid_next = 1'b1;
        end
        out_valid_next = out_valid_reg;
        if (out_free)
        begin
            out_valid_next = cur_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        if (emit)
        begin
            kind_reg   <= kind_next;
            dx_reg     <= dx_next;
            dy_reg     <= dy_next;
            button_reg <= button_next;
            last_reg   <= last_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign event_ch.valid         = out_valid_reg;
    assign event_ch.event_kind    = kind_reg;
    assign event_ch.delta_x       = dx_reg;
    assign event_ch.delta_y       = dy_reg;
    assign event_ch.button_number = button_reg;
    assign event_ch.last_event    = last_reg;

endmodule

### hdl/ps2_mouse_packet_decoder.sv
// Channel    Dir   Payload                                          Handshake
// byte_ch    in    status_byte[7:0], data_byte[7:0]                 valid/ready
// event_ch   out   event_kind, delta_x, delta_y, button_number,     valid/ready
//                  last_event
//
// A byte beat is taken in any cycle the packet queue has room; bytes without
// the mouse flag in status bit 5 are dropped there. The event sequencer puts
// out one event per cycle while event_ch accepts them, also across packets.
// Events pass through the queue, the current-packet reg and the output reg.
// Reset (async, active low) clears packet assembly, button state and queue.
// Event stalls fill the queue (QUEUE_DEPTH packets) before byte_ch stalls.
module ps2_mouse_packet_decoder #(
    parameter int unsigned QUEUE_DEPTH = pmpd_pkg::DEF_QUEUE_DEPTH
) (
    input  logic         clk,
    input  logic         rst_n,
    pmpd_byte_if.sink    byte_ch,
    pmpd_event_if.source event_ch
);
    import pmpd_pkg::*;

    logic   push;
    logic   pop;
    pkt_t   push_pkt;
    pkt_t   pop_pkt;
    qstat_t q_stat;

    // Front: assemble three-byte packets, classify events, track buttons.
    pmpd_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .byte_ch  (byte_ch),
        .q_stat   (q_stat),
        .push     (push),
        .push_pkt (push_pkt)
    );

    // Queue of packet descriptors decouples assembly from event output.
    pmpd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_pkt (push_pkt),
        .pop      (pop),
        .pop_pkt  (pop_pkt),
        .q_stat   (q_stat)
    );

    // Back: walk the pending event slots, one beat per cycle unless event_ch stalls.
    pmpd_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_stat   (q_stat),
        .pop_pkt  (pop_pkt),
        .pop      (pop),
        .event_ch (event_ch)
    );

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !q_stat.full)
        else $error("packet pushed into full queue");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_stat.empty)
        else $error("packet popped from empty queue");

    a_move_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (event_ch.valid && event_ch.event_kind == EV_MOVE) |-> event_ch.button_number == 2'd0)
        else $error("move event carries a button number");

    a_button_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (event_ch.valid && event_ch.event_kind != EV_MOVE)
            |-> (event_ch.delta_x == 8'sd0 && event_ch.delta_y == 9'sd0
                 && event_ch.button_number != 2'd0))
        else $error("button event fields inconsistent");

endmodule

### test/pmpd_event_checker.sv
`timescale 1ns / 1ps

module pmpd_event_checker (
    input  logic  clk,
    input  logic  rst_n,
    pmpd_byte_if  byte_ch,
    pmpd_event_if event_ch,
    output int    fail_count,
    output int    events_pending
);
    import pmpd_pkg::*;

    typedef struct packed {
        event_kind_t kind;
        logic [7:0]  dx;
        logic [8:0]  dy;
        logic [1:0]  button;
        logic        last;
    } mouse_event_t;

    // shadow copy of the packet assembly and button state
    logic [1:0]             pkt_pos;
    logic [7:0]             pkt_flags;
    logic [7:0]             pkt_dx;
    logic [NUM_BUTTONS-1:0] held_buttons;

    mouse_event_t expected_events[$];

    task automatic note_mismatch(input string msg);
        $display("ERROR %0t: %s", $realtime, msg);
        fail_count = fail_count + 1;
    endtask

    // Work out the events caused by one byte beat and queue them.
    task automatic take_mouse_byte(input logic [7:0] status, input logic [7:0] data);
        mouse_event_t      batch[NUM_EVENT_SLOTS];
        logic signed [8:0] dy_ext;
        int                n;
        n = 0;
        if (!status[MOUSE_FLAG_BIT])
            return;
        case (pkt_pos)
            2'd0:
            begin
                pkt_flags = data;
                pkt_pos   = 2'd1;
            end
            2'd1:
            begin
                pkt_dx  = data;
                pkt_pos = 2'd2;
            end
            default:
            begin
                // third byte, or the unused position: close the packet
                pkt_pos = 2'd0;
                if (pkt_dx != 8'd0 || data != 8'd0)
                begin
                    dy_ext   = {data[7], data};
                    batch[n] = '{kind: EV_MOVE, dx: pkt_dx, dy: -dy_ext,
                                 button: 2'd0, last: 1'b0};
                    n++;
                end
                for (int b = 0; b < NUM_BUTTONS; b++)
                begin
                    if (pkt_flags[b] != held_buttons[b])
                    begin
                        batch[n] = '{kind: held_buttons[b] ? EV_RELEASE : EV_PRESS,
                                     dx: 8'd0, dy: 9'd0, button: 2'(b + 1),
                                     last: 1'b0};
                        n++;
                    end
                end
                held_buttons = pkt_flags[NUM_BUTTONS-1:0];
                if (n > 0)
                    batch[n-1].last = 1'b1;
                for (int k = 0; k < n; k++)
                    expected_events.push_back(batch[k]);
            end
        endcase
    endtask

    task automatic check_event();
        mouse_event_t got;
        mouse_event_t want;
        got = '{kind: event_kind_t'(event_ch.event_kind), dx: event_ch.delta_x,
                dy: event_ch.delta_y, button: event_ch.button_number,
                last: event_ch.last_event};
        if (expected_events.size() == 0)
        begin
            note_mismatch($sformatf(
                "event with none expected: kind %0d dx %0d dy %0d btn %0d last %0b",
                got.kind, $signed(got.dx), $signed(got.dy), got.button, got.last));
            return;
        end
        want = expected_events.pop_front();
        if (got !== want)
            note_mismatch($sformatf(
                "event kind %0d dx %0d dy %0d btn %0d last %0b, want %0d %0d %0d %0d %0b",
                got.kind, $signed(got.dx), $signed(got.dy), got.button, got.last,
                want.kind, $signed(want.dx), $signed(want.dy), want.button, want.last));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pkt_pos      = 2'd0;
            pkt_flags    = 8'd0;
            pkt_dx       = 8'd0;
            held_buttons = '0;
            fail_count   = 0;
            expected_events.delete();
            events_pending <= 0;
        end
        else
        begin
            if (byte_ch.valid && byte_ch.ready)
                take_mouse_byte(byte_ch.status_byte, byte_ch.data_byte);
            if (event_ch.valid && event_ch.ready)
                check_event();
            events_pending <= expected_events.size();
        end
    end

endmodule

### test/tb.sv
`timescale 1ns / 1ps

module tb;

    import pmpd_pkg::*;

    localparam int         CYCLE_LIMIT = 200000;
    localparam logic [7:0] MOUSE_MARK  = 8'(1 << MOUSE_FLAG_BIT);

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    // shared pacing controls; all written with nonblocking assignments at the edge
    logic rx_hold = 1'b0;       // receiver holds off completely
    logic no_idle = 1'b0;       // both sides run without gaps
    logic hold_armed = 1'b0;    // start the long receiver hold-off

    int fail_count;
    int events_pending;
    int cycle_count = 0;

    pmpd_byte_if  byte_ch ();
    pmpd_event_if event_ch ();

    ps2_mouse_packet_decoder i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .byte_ch  (byte_ch),
        .event_ch (event_ch)
    );

    pmpd_event_checker i_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .byte_ch        (byte_ch),
        .event_ch       (event_ch),
        .fail_count     (fail_count),
        .events_pending (events_pending)
    );

    always #2 clk = ~clk;

    // Drive every input to a known value before the first edge.
    initial
    begin
        byte_ch.valid       = 1'b0;
        byte_ch.status_byte = 8'd0;
        byte_ch.data_byte   = 8'd0;
        event_ch.ready      = 1'b0;
    end

    // Event side: drop ready with a chance of about 17 in 100, hold it off
    // entirely during the pressure window, and keep it high in the steady stretch.
    always @(posedge clk)
    begin
        if (rx_hold)
            event_ch.ready <= 1'b0;
        else if (no_idle)
            event_ch.ready <= 1'b1;
        else
            event_ch.ready <= ($urandom_range(0, 99) >= 17);
    end

    // Long hold-off: keep the event side stalled long enough that the packet
    // queue fills and the byte channel has to stall as well.
    initial
    begin
        wait (hold_armed);
        @(posedge clk);
        rx_hold <= 1'b1;
        for (int n = 0; n < 80; n++)
            @(posedge clk);
        rx_hold <= 1'b0;
    end

    // Watchdog: end the run if the block hangs.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAIL ps2_mouse_packet_decoder");
            $finish;
        end
    end

    // Offer one byte beat and hold it until the block takes it. Insert random
    // gaps first unless the sender is meant to keep pushing.
    task automatic push_byte(input logic [7:0] status, input logic [7:0] data);
        while (!(no_idle || rx_hold) && $urandom_range(0, 99) < 17)
        begin
            byte_ch.valid <= 1'b0;
            @(posedge clk);
        end
        byte_ch.valid       <= 1'b1;
        byte_ch.status_byte <= status;
        byte_ch.data_byte   <= data;
        do
            @(posedge clk);
        while (!byte_ch.ready);
    endtask

    // Mouse byte with the other status bits at random.
    task automatic push_mouse(input logic [7:0] data);
        push_byte(8'($urandom_range(0, 255)) | MOUSE_MARK, data);
    endtask

    task automatic push_packet(input logic [7:0] flags, input logic [7:0] dx,
                               input logic [7:0] dy);
        push_mouse(flags);
        push_mouse(dx);
        push_mouse(dy);
    endtask

    // Delta byte: zero about one time in five so single-axis and quiet
    // packets come up often.
    function automatic logic [7:0] pick_delta();
        if ($urandom_range(0, 4) == 0)
            return 8'd0;
        return 8'($urandom_range(0, 255));
    endfunction

    initial
    begin
        int mouse_items;
        mouse_items = 0;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // non-mouse bytes: all status bits but the mouse flag, and none
        push_byte(8'h00, 8'hFF);
        push_byte(~MOUSE_MARK, 8'hFF);
        // largest deltas, all three buttons pressed: four events
        push_packet(8'h07, 8'h7F, 8'h80);
        // most negative dx, dy of +127, all three buttons released
        push_packet(8'h00, 8'h80, 8'h7F);
        // quiet packet: no deltas, no button change, nothing comes out
        push_packet(8'h00, 8'h00, 8'h00);
        // stray flag bits set, button 2 pressed; a non-mouse byte mid-packet is dropped
        push_byte(8'h20, 8'hFA);
        push_byte(~MOUSE_MARK, 8'h55);
        push_byte(8'hFF, 8'h00);
        push_byte(8'h20, 8'hFF);
        // small move and button 2 released
        push_packet(8'hF8, 8'h01, 8'h00);

        // Random part: mostly clean packets with random content, some noise.
        // The hold-off starts here while the sender keeps pushing.
        hold_armed <= 1'b1;
        while (mouse_items < 102)
        begin
            if ($urandom_range(0, 9) == 0)
                push_byte(8'($urandom_range(0, 255)) & ~MOUSE_MARK,
                          8'($urandom_range(0, 255)));
            else
            begin
                if (mouse_items % 3 == 0)
                    push_mouse(8'($urandom_range(0, 255)));
                else
                    push_mouse(pick_delta());
                mouse_items++;
                no_idle <= (mouse_items >= 40 && mouse_items < 80);
            end
        end
        byte_ch.valid <= 1'b0;
        @(posedge clk);

        // drain until the checker expects no more events, then watch for any stray event
        wait (events_pending == 0);
        repeat (20) @(posedge clk);

        if (fail_count == 0)
            $display("PASS ps2_mouse_packet_decoder");
        else
            $display("FAIL ps2_mouse_packet_decoder");
        $finish;
    end

endmodule
